/* src/odo_pkg.sv */
// ---------------------------------------------------------------------------
// odo_pkg: shared types and constants of the wheel odometry unit
// Fixed-point widths, register codes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none
package odo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int POSE_WIDTH   = 32;

   localparam int DW      = 17;   // wheel delta, signed
   localparam int DIST_W  = 31;   // wheel distance, signed
   localparam int CW      = 36;   // CORDIC datapath, signed
   localparam int DIV_NW  = 50;   // divider numerator
   localparam int DIV_DW  = 31;   // divider denominator
   localparam int SQ_W    = 62;   // square root datapath
   localparam int CNT_W   = $clog2(CORDIC_STEPS);

   localparam logic [14:0] FULL_TURN = 15'd23040;
   localparam logic signed [16:0] HALF_PI_H = 17'sd12868;
   localparam logic signed [16:0] PI_H      = 17'sd25736;
   localparam logic signed [16:0] TWO_PI_H  = 17'sd51472;
   localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;

   typedef enum logic [2:0] {
      CSR_ROLLOVER = 3'd0,
      CSR_SETTLE   = 3'd1,
      CSR_GEAR     = 3'd2,
      CSR_CIRC     = 3'd3,
      CSR_BASE     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [14:0] rollover_threshold;
      logic [15:0] gear_ratio;
      logic [19:0] wheel_circumference;
      logic [19:0] wheel_base;
   } cfg_type;

   typedef struct packed {
      logic       load;
      logic [7:0] value;
   } settle_load_type;

   typedef struct packed {
      logic signed [DW-1:0] dl;
      logic signed [DW-1:0] dr;
   } delta_type;

   function automatic logic signed [CW-1:0] atan_entry(input logic [CNT_W-1:0] i);
      logic signed [CW-1:0] v;
      v = '0;
      case (int'(i))
         0: v = 36'sd843314856;
         1: v = 36'sd497837829;
         2: v = 36'sd263043836;
         3: v = 36'sd133525158;
         4: v = 36'sd67021686;
         5: v = 36'sd33543515;
         6: v = 36'sd16775850;
         7: v = 36'sd8388437;
         8: v = 36'sd4194282;
         9: v = 36'sd2097149;
         default: begin
            if (int'(i) <= 30) begin
               v = signed'((CW'(1) << (30 - int'(i))) - CW'(1));
            end else begin
               v = '0;
            end
         end
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* src/odo_front.sv */
// ---------------------------------------------------------------------------
// odo_front: reading intake and wheel delta stage
// Keeps latest and previous readings per wheel, forms rollover-corrected
// deltas with settling once both wheels have reported, and queues them.
// ---------------------------------------------------------------------------
`default_nettype none
module odo_front import odo_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   input  wire settle_load_type settle_load,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [15:0]     req_tdata,   // [14:0] angle_reading
   input  wire logic [0:0]      req_tuser,   // [0] mode
   input  wire logic            q_full,
   output logic                 q_push,
   output delta_type            q_data
);

   logic [14:0] left_latest_ff, left_latest_in, right_latest_ff, right_latest_in;
   logic [14:0] left_prev_ff, left_prev_in, right_prev_ff, right_prev_in;
   logic        left_ready_ff, left_ready_in, right_ready_ff, right_ready_in;
   logic [7:0]  settle_ff, settle_in, settle_mid;
   logic        accept, frame, mode, zero_l, zero_r;
   logic [14:0] reading, left_new, right_new;
   logic signed [DW-1:0] raw_l, raw_r;

   function automatic logic signed [DW-1:0] wheel_delta(input logic [14:0] cur,
                                                         input logic [14:0] prev,
                                                         input logic [14:0] thr);
      logic signed [DW-1:0] d, t;
      d = signed'({2'b00, cur}) - signed'({2'b00, prev});
      t = signed'({2'b00, thr});
      if (d > t) begin
         d = d - signed'({2'b00, FULL_TURN});
      end else if (d < -t) begin
         d = d + signed'({2'b00, FULL_TURN});
      end
      return d;
   endfunction

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign mode       = req_tuser[0];
   assign reading    = req_tdata[14:0];
   assign left_new   = mode ? left_latest_ff : reading;
   assign right_new  = mode ? reading : right_latest_ff;
   assign frame      = accept && (mode ? left_ready_ff : right_ready_ff);

   assign raw_l      = wheel_delta(left_new, left_prev_ff, cfg.rollover_threshold);
   assign raw_r      = wheel_delta(right_new, right_prev_ff, cfg.rollover_threshold);
   // left is settled first, then right
   assign zero_l     = settle_ff != 8'd0;
   assign settle_mid = settle_ff - {7'd0, zero_l};
   assign zero_r     = settle_mid != 8'd0;

   assign q_push     = frame;
   assign q_data.dl  = zero_l ? '0 : -raw_l;
   assign q_data.dr  = zero_r ? '0 : raw_r;

   always_comb begin
      left_latest_in  = left_latest_ff;
      right_latest_in = right_latest_ff;
      left_prev_in    = left_prev_ff;
      right_prev_in   = right_prev_ff;
      left_ready_in   = left_ready_ff;
      right_ready_in  = right_ready_ff;
      settle_in       = settle_ff;
      if (accept) begin
         left_latest_in  = left_new;
         right_latest_in = right_new;
         if (frame) begin
            left_ready_in  = 1'b0;
            right_ready_in = 1'b0;
            left_prev_in   = left_new;
            right_prev_in  = right_new;
            settle_in      = settle_mid - {7'd0, zero_r};
         end else if (mode) begin
            right_ready_in = 1'b1;
         end else begin
            left_ready_in = 1'b1;
         end
      end
      if (settle_load.load) begin
         settle_in = settle_load.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_latest_ff  <= '0;
         right_latest_ff <= '0;
         left_prev_ff    <= '0;
         right_prev_ff   <= '0;
         left_ready_ff   <= 1'b0;
         right_ready_ff  <= 1'b0;
         settle_ff       <= '0;
      end else begin
         left_latest_ff  <= left_latest_in;
         right_latest_ff <= right_latest_in;
         left_prev_ff    <= left_prev_in;
         right_prev_ff   <= right_prev_in;
         left_ready_ff   <= left_ready_in;
         right_ready_ff  <= right_ready_in;
         settle_ff       <= settle_in;
      end
   end

endmodule
`default_nettype wire

/* src/odo_queue.sv */
// ---------------------------------------------------------------------------
// odo_queue: two-entry delta queue
// Decouples the reading intake from the frame sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module odo_queue import odo_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire delta_type push_data,
   input  wire logic      pop,
   output logic           full,
   output logic           valid,
   output delta_type      head
);

   delta_type   mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* src/odo_div.sv */
// ---------------------------------------------------------------------------
// odo_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when finished.
// ---------------------------------------------------------------------------
`default_nettype none
module odo_div import odo_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_NW-1:0] num,
   input  wire logic [DIV_DW-1:0] den,
   output logic [DIV_NW-1:0]      quot,
   output logic                   done
);

   localparam int DCNT_W = $clog2(DIV_NW);

   logic [DIV_NW-1:0] quot_ff, quot_in;
   logic [DIV_DW-1:0] den_ff, den_in;
   logic [DIV_DW:0]   rem_ff, rem_in, rem_sh;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in, ge;

   assign rem_sh = {rem_ff[DIV_DW-1:0], quot_ff[DIV_NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign quot   = quot_ff;
   assign done   = done_ff;

   always_comb begin
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         quot_in = {quot_ff[DIV_NW-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(DIV_NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule
`default_nettype wire

/* src/odo_back.sv */
// ---------------------------------------------------------------------------
// odo_back: frame sequencer
// Distances, arcsine heading step, sine-cosine and pose update for one
// frame, through a shared divider, a square root loop and a shared CORDIC.
// ---------------------------------------------------------------------------
`default_nettype none
module odo_back import odo_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cfg_type   cfg,
   input  wire logic      q_valid,
   input  wire delta_type q_head,
   output logic           q_pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output logic [111:0]   rsp_tdata
);

   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_DIST_L = 17'h00002,
      ST_DIST_R = 17'h00004,
      ST_DIFF   = 17'h00008,
      ST_ASIN   = 17'h00010,
      ST_SQ     = 17'h00020,
      ST_SQRT0  = 17'h00040,
      ST_SQRT   = 17'h00080,
      ST_VINIT  = 17'h00100,
      ST_VEC    = 17'h00200,
      ST_ROUND  = 17'h00400,
      ST_HEAD   = 17'h00800,
      ST_ROT    = 17'h01000,
      ST_MUL_X  = 17'h02000,
      ST_MUL_Y  = 17'h04000,
      ST_ACC_Y  = 17'h08000,
      ST_OUT    = 17'h10000
   } state_type;

   localparam int PW = POSE_WIDTH;

   state_type state_ff, state_in;

   logic signed [DW-1:0]     dr_ff, dr_in;
   logic                     dneg_ff, dneg_in;
   logic signed [DIST_W-1:0] ml_ff, ml_in, mr_ff, mr_in, fd_ff, fd_in;
   logic [29:0]              s_mag_ff, s_mag_in;
   logic                     s_neg_ff, s_neg_in;
   logic [59:0]              sq_ff, sq_in;
   logic [SQ_W-1:0]          n_ff, n_in, res_ff, res_in, bit_ff, bit_in, sq_t;
   logic signed [CW-1:0]     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CW-1:0]     xs, ys, at, zr, zh, cneg;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [16:0]       ang_ff, ang_in, hsum, hwrap;
   logic signed [15:0]       heading_ff, heading_in;
   logic                     neg_ff, neg_in, up;
   logic signed [63:0]       prod_ff, prod_in;
   logic [PW-1:0]            x_acc_ff, x_acc_in, y_acc_ff, y_acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [111:0]             rsp_data_ff, rsp_data_in;

   logic                     div_start, div_done;
   logic [DIV_NW-1:0]        div_num, div_quot;
   logic [DIV_DW-1:0]        div_den, den_dist;
   logic [15:0]              gear_eff;
   logic signed [31:0]       sum, diff, mag;
   logic signed [DIST_W-1:0] dist_q;

   function automatic logic [DIV_NW-1:0] dist_num(input logic signed [DW-1:0] d,
                                                  input logic [19:0] circ);
      logic [DW-1:0] m;
      logic [35:0]   p;
      m = d[DW-1] ? DW'(-d) : DW'(d);
      p = {20'd0, m[15:0]} * {16'd0, circ};
      return DIV_NW'({p, 8'd0});
   endfunction

   function automatic logic [PW-1:0] round_q30(input logic signed [63:0] p);
      logic signed [79:0] w;
      w = signed'({{16{p[63]}}, p}) + 80'sd536870912;
      w = w >>> 30;
      return w[PW-1:0];
   endfunction

   function automatic logic [31:0] pose_out(input logic [PW-1:0] a);
      logic [63:0] w;
      w = {{(64 - PW){1'b0}}, a};
      return w[31:0];
   endfunction

   odo_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .done  (div_done)
   );

   assign gear_eff = (cfg.gear_ratio == 16'd0) ? 16'd1 : cfg.gear_ratio;
   assign den_dist = DIV_DW'({16'd0, FULL_TURN} * {15'd0, gear_eff});
   assign dist_q   = dneg_ff ? -DIST_W'(div_quot[29:0]) : DIST_W'(div_quot[29:0]);

   assign sum  = 32'(ml_ff) + 32'(mr_ff);
   assign diff = 32'(mr_ff) - 32'(ml_ff);
   assign mag  = diff[31] ? -diff : diff;

   // shared CORDIC step: vectoring drives y to zero, rotation drives z to zero
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign at = atan_entry(cnt_ff);
   assign up = (state_ff == ST_ROT) ? !z_ff[CW-1] : !(y_ff > 0);

   assign sq_t  = res_ff + bit_ff;
   assign zr    = (z_ff + 36'sd65536) >>> 17;
   assign hsum  = 17'(heading_ff) + ang_ff;
   assign hwrap = (hsum > PI_H) ? hsum - TWO_PI_H :
                  (hsum < -PI_H) ? hsum + TWO_PI_H : hsum;
   assign zh    = signed'({{(CW - 34){hwrap[16]}}, hwrap, 17'd0});
   assign cneg  = -x_ff;

   always_comb begin
      state_in   = state_ff;
      dr_in      = dr_ff;
      dneg_in    = dneg_ff;
      ml_in      = ml_ff;
      mr_in      = mr_ff;
      fd_in      = fd_ff;
      s_mag_in   = s_mag_ff;
      s_neg_in   = s_neg_ff;
      sq_in      = sq_ff;
      n_in       = n_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      cnt_in     = cnt_ff;
      ang_in     = ang_ff;
      heading_in = heading_ff;
      neg_in     = neg_ff;
      prod_in    = prod_ff;
      x_acc_in   = x_acc_ff;
      y_acc_in   = y_acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      q_pop      = 1'b0;
      div_start  = 1'b0;
      div_num    = dist_num(dr_ff, cfg.wheel_circumference);
      div_den    = den_dist;

      unique case (state_ff) inside
         ST_IDLE: begin
            div_num = dist_num(q_head.dl, cfg.wheel_circumference);
            if (q_valid) begin
               q_pop     = 1'b1;
               div_start = 1'b1;
               dr_in     = q_head.dr;
               dneg_in   = q_head.dl[DW-1];
               state_in  = ST_DIST_L;
            end
         end
         ST_DIST_L: begin
            if (div_done) begin
               ml_in     = dist_q;
               div_start = 1'b1;
               dneg_in   = dr_ff[DW-1];
               state_in  = ST_DIST_R;
            end
         end
         ST_DIST_R: begin
            if (div_done) begin
               mr_in    = dist_q;
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // truncate the mean toward zero
            fd_in    = DIST_W'((sum + {31'd0, sum[31]}) >>> 1);
            s_neg_in = diff[31];
            div_num  = {mag[19:0], 30'd0};
            div_den  = {11'd0, cfg.wheel_base};
            if (diff == 32'sd0) begin
               ang_in   = '0;
               state_in = ST_HEAD;
            end else if (mag >= signed'({12'd0, cfg.wheel_base})) begin
               ang_in   = diff[31] ? -HALF_PI_H : HALF_PI_H;
               state_in = ST_HEAD;
            end else begin
               div_start = 1'b1;
               state_in  = ST_ASIN;
            end
         end
         ST_ASIN: begin
            if (div_done) begin
               s_mag_in = div_quot[29:0];
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            sq_in    = {30'd0, s_mag_ff} * {30'd0, s_mag_ff};
            state_in = ST_SQRT0;
         end
         ST_SQRT0: begin
            n_in     = (SQ_W'(1) << 60) - {2'd0, sq_ff};
            res_in   = '0;
            bit_in   = SQ_W'(1) << 60;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (n_ff >= sq_t) begin
               n_in   = n_ff - sq_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == SQ_W'(1)) begin
               state_in = ST_VINIT;
            end
         end
         ST_VINIT: begin
            x_in     = signed'(CW'(res_ff[30:0]));
            y_in     = s_neg_ff ? -signed'(CW'(s_mag_ff)) : signed'(CW'(s_mag_ff));
            z_in     = '0;
            cnt_in   = '0;
            state_in = ST_VEC;
         end
         ST_VEC, ST_ROT: begin
            if (up) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = (state_ff == ST_VEC) ? ST_ROUND : ST_MUL_X;
            end
         end
         ST_ROUND: begin
            ang_in   = zr[16:0];
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            heading_in = hwrap[15:0];
            x_in       = GAIN_Q30;
            y_in       = '0;
            cnt_in     = '0;
            // fold headings beyond a quarter turn and negate the results
            if (zh > HALF_PI_Q30) begin
               z_in   = zh - PI_Q30;
               neg_in = 1'b1;
            end else if (zh < -HALF_PI_Q30) begin
               z_in   = zh + PI_Q30;
               neg_in = 1'b1;
            end else begin
               z_in   = zh;
               neg_in = 1'b0;
            end
            state_in = ST_ROT;
         end
         ST_MUL_X: begin
            prod_in  = signed'(neg_ff ? cneg[31:0] : x_ff[31:0]) * 32'(fd_ff);
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            x_acc_in = x_acc_ff + round_q30(prod_ff);
            prod_in  = signed'(neg_ff ? 32'(-y_ff) : y_ff[31:0]) * 32'(fd_ff);
            state_in = ST_ACC_Y;
         end
         ST_ACC_Y: begin
            y_acc_in = y_acc_ff + round_q30(prod_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {32'(fd_ff), heading_ff,
                               pose_out(y_acc_ff), pose_out(x_acc_ff)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      dr_ff       <= dr_in;
      dneg_ff     <= dneg_in;
      ml_ff       <= ml_in;
      mr_ff       <= mr_in;
      fd_ff       <= fd_in;
      s_mag_ff    <= s_mag_in;
      s_neg_ff    <= s_neg_in;
      sq_ff       <= sq_in;
      n_ff        <= n_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      cnt_ff      <= cnt_in;
      ang_ff      <= ang_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         heading_ff   <= '0;
         x_acc_ff     <= '0;
         y_acc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         x_acc_ff     <= x_acc_in;
         y_acc_ff     <= y_acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* src/differential_drive_odometry_unit.sv */
// Sequence: a frame result follows the completing reading after three divider
// runs, a 31-step square root and two CORDIC passes; zero or saturated turns
// skip the third divider run, the square root and the vectoring pass.
// Flow: readings enter one per cycle into a two-entry delta queue while it
// is not full; frames run one at a time.
// Reset: synchronous, clears pose, heading, readings and restores registers.
// ---------------------------------------------------------------------------
// differential_drive_odometry_unit: wheel encoder odometry
// Register file, reading intake, delta queue and frame sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module differential_drive_odometry_unit import odo_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [15:0]   req_tdata,   // [14:0] angle_reading
   input  wire logic [0:0]    req_tuser,   // [0] mode
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [111:0]       rsp_tdata,   // [31:0] pos_x, [63:32] pos_y,
                                           // [79:64] heading, [111:80] frame_distance
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [19:0]   csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   settle_load_type settle_load;
   logic            csr_write, q_push, q_full, q_valid, q_pop;
   delta_type       q_push_data, q_head;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in            = cfg_ff;
      settle_load.load  = 1'b0;
      settle_load.value = csr_wdata[7:0];
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROLLOVER: cfg_in.rollover_threshold  = csr_wdata[14:0];
            CSR_SETTLE:   settle_load.load           = 1'b1;
            CSR_GEAR:     cfg_in.gear_ratio          = csr_wdata[15:0];
            CSR_CIRC:     cfg_in.wheel_circumference = csr_wdata;
            CSR_BASE:     cfg_in.wheel_base          = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rollover_threshold  <= 15'd11520;
         cfg_ff.gear_ratio          <= 16'd256;
         cfg_ff.wheel_circumference <= 20'd32768;
         cfg_ff.wheel_base          <= 20'd32768;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   odo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .settle_load (settle_load),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_push_data)
   );

   odo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   odo_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
